/* rtl/ialu_pkg.sv */
package ialu_pkg;

  // Default widths for the top level parameters.
  localparam int unsigned DataWidthDef    = 32;
  localparam int unsigned RootFracBitsDef = 16;

  // Operation codes carried in the input tuser.
  localparam logic [2:0] FUNC_ADD  = 3'd0;
  localparam logic [2:0] FUNC_SUB  = 3'd1;
  localparam logic [2:0] FUNC_MUL  = 3'd2;
  localparam logic [2:0] FUNC_DIV  = 3'd3;
  localparam logic [2:0] FUNC_POW  = 3'd4;
  localparam logic [2:0] FUNC_ROOT = 3'd5;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_ROOT = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
  } sts_t;

endpackage

/* rtl/ialu_dp.sv */
module ialu_dp #(
  parameter int unsigned DATA_WIDTH     = ialu_pkg::DataWidthDef,
  parameter int unsigned ROOT_FRAC_BITS = ialu_pkg::RootFracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ialu_pkg::cmd_t     cmd_i,
  output ialu_pkg::sts_t     sts_o,
  input  logic [2:0]         func_i,
  input  logic [31:0]        operand_a_i,
  input  logic [31:0]        operand_b_i,
  output logic [31:0]        int_result_o,
  output logic [31:0]        root_q16_o,
  output logic [1:0]         status_o
);
  import ialu_pkg::*;

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned RADW = DW + 2 * ROOT_FRAC_BITS + (DW % 2);
  localparam int unsigned HALF = RADW / 2;
  localparam int unsigned MAXN = (DW > HALF) ? DW : HALF;
  localparam int unsigned CW   = (MAXN > 2) ? $clog2(MAXN) : 1;

  logic [DW-1:0] a_u, b_u;
  logic          a_neg, b_neg;
  logic [DW-1:0] a_mag, b_mag;

  logic [2:0]      func_q;
  logic            active_q, active_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [DW-1:0]   acc_q, acc_d;
  logic [DW-1:0]   base_q, base_d;
  logic [DW-1:0]   exp_q, exp_d;
  logic            phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [DW-1:0]   dvd_q, dvd_d;
  logic [DW-1:0]   dvs_q, dvs_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [RADW-1:0] rad_q, rad_d;
  logic [HALF:0]   srem_q, srem_d;
  logic [HALF-1:0] res_q, res_d;
  status_e         st_q, st_d;

  logic [DW-1:0]   mul_x, mul_y, mul_p;
  logic [DW:0]     rem_sh, rem_sub;
  logic            div_bit;
  logic [DW-1:0]   quo;
  logic [HALF+2:0] srem_sh, strial, ssub;
  logic            sq_bit;

  // Operands are taken at the datapath width.
  assign a_u   = operand_a_i[DW-1:0];
  assign b_u   = operand_b_i[DW-1:0];
  assign a_neg = a_u[DW-1];
  assign b_neg = b_u[DW-1];
  assign a_mag = a_neg ? (~a_u + DW'(1)) : a_u;
  assign b_mag = b_neg ? (~b_u + DW'(1)) : b_u;

  // One shared multiplier for multiply and the power steps.
  always_comb begin
    mul_x = a_u;
    mul_y = b_u;
    if (!cmd_i.start) begin
      if (phase_q) begin
        mul_x = base_q;
        mul_y = base_q;
      end else begin
        mul_x = acc_q;
        mul_y = base_q;
      end
    end
  end
  assign mul_p = mul_x * mul_y;

  // Restoring divide step on magnitudes.
  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign div_bit = !rem_sub[DW];
  assign quo     = {dvd_q[DW-2:0], div_bit};

  // Digit-by-digit root step, two radicand bits per cycle.
  assign srem_sh = {srem_q, rad_q[RADW-1 -: 2]};
  assign strial  = {1'b0, res_q, 2'b01};
  assign ssub    = srem_sh - strial;
  assign sq_bit  = !ssub[HALF+2];

  // Next state of the datapath.
  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    base_d   = base_q;
    exp_d    = exp_q;
    phase_d  = phase_q;
    neg_d    = neg_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    rad_d    = rad_q;
    srem_d   = srem_q;
    res_d    = res_q;
    st_d     = st_q;
    if (cmd_i.start) begin
      active_d = 1'b0;
      acc_d    = '0;
      res_d    = '0;
      st_d     = ST_OK;
      phase_d  = 1'b0;
      unique case (func_i)
        FUNC_ADD: acc_d = a_u + b_u;
        FUNC_SUB: acc_d = a_u - b_u;
        FUNC_MUL: acc_d = mul_p;
        FUNC_DIV: begin
          if (b_u == '0) begin
            st_d = ST_DIV0;
          end else begin
            active_d = 1'b1;
            dvd_d    = a_mag;
            dvs_d    = b_mag;
            rem_d    = '0;
            neg_d    = a_neg ^ b_neg;
            cnt_d    = CW'(DW - 1);
          end
        end
        FUNC_POW: begin
          priority if (!b_neg && (b_u != '0)) begin
            active_d = 1'b1;
            acc_d    = DW'(1);
            base_d   = a_u;
            exp_d    = b_u;
          end else if (b_u == '0) begin
            acc_d = DW'(1);
          end else if (a_u == '0) begin
            st_d = ST_DIV0;
          end else if (a_u == DW'(1)) begin
            acc_d = DW'(1);
          end else if (a_u == '1) begin
            acc_d = b_u[0] ? '1 : DW'(1);
          end else begin
            acc_d = '0;
          end
        end
        FUNC_ROOT: begin
          if (a_neg || (a_u == '0)) begin
            st_d = ST_ROOT;
          end else begin
            active_d = 1'b1;
            rad_d    = RADW'(a_u) << (2 * ROOT_FRAC_BITS);
            srem_d   = '0;
            cnt_d    = CW'(HALF - 1);
          end
        end
        default: ;
      endcase
    end else if (cmd_i.step && active_q) begin
      unique case (func_q)
        FUNC_DIV: begin
          rem_d = div_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
          dvd_d = quo;
          cnt_d = cnt_q - CW'(1);
          if (cnt_q == '0) begin
            active_d = 1'b0;
            acc_d    = neg_q ? (~quo + DW'(1)) : quo;
          end
        end
        FUNC_POW: begin
          if (!phase_q) begin
            if (exp_q[0]) acc_d = mul_p;
            phase_d = 1'b1;
          end else begin
            base_d  = mul_p;
            exp_d   = exp_q >> 1;
            phase_d = 1'b0;
            if ((exp_q >> 1) == '0) active_d = 1'b0;
          end
        end
        FUNC_ROOT: begin
          srem_d = sq_bit ? ssub[HALF:0] : srem_sh[HALF:0];
          res_d  = {res_q[HALF-2:0], sq_bit};
          rad_d  = rad_q << 2;
          cnt_d  = cnt_q - CW'(1);
          if (cnt_q == '0) active_d = 1'b0;
        end
        default: active_d = 1'b0;
      endcase
    end
  end

  // Control registers of the datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phase_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) func_q <= func_i;
    acc_q  <= acc_d;
    base_q <= base_d;
    exp_q  <= exp_d;
    neg_q  <= neg_d;
    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
    rad_q  <= rad_d;
    srem_q <= srem_d;
    res_q  <= res_d;
    st_q   <= st_d;
  end

  // Output register, loaded when the finished item moves out.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      int_result_o <= 32'($signed(acc_q));
      root_q16_o   <= 32'(res_q);
      status_o     <= st_q;
    end
  end

  assign sts_o.done = !active_q;

endmodule

/* rtl/ialu_ctrl.sv */
module ialu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ialu_pkg::cmd_t cmd_o,
  input  ialu_pkg::sts_t sts_i
);
  import ialu_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   out_free;

  assign out_free   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencing of one item through the datapath.
  always_comb begin
    state_d        = state_q;
    cmd_o.start    = 1'b0;
    cmd_o.step     = 1'b0;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_BUSY;
        end
      end
      S_BUSY: begin
        cmd_o.step = 1'b1;
        if (sts_i.done && out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid flag of the output register.
  always_comb begin
    if (cmd_o.load_out) ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
    else ovalid_d = ovalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |-> state_q == S_IDLE) else $error("start outside idle");
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> sts_i.done && out_free) else $error("early or blocked load");
  a_busy_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUSY) && !sts_i.done |=> state_q == S_BUSY) else $error("left busy early");

endmodule

/* rtl/integer_alu_pow_sqrt.sv */
// Channel  | Direction | tdata (low bit up)            | tuser
// s_axis   | in        | operand_a[31:0], operand_b    | func[2:0]
// m_axis   | out       | int_result[31:0], root_q16    | status[1:0]
//
// An item is accepted in idle; a result then comes after the datapath finishes.
// Add, subtract, multiply and the special power cases need no datapath steps.
// Divide and power run as repeated datapath steps, power on the multiplier.
// Square root runs as repeated root steps.
// Reset is asynchronous and active low; a held result stalls the next completion
// while the next item can still be accepted.
module integer_alu_pow_sqrt #(
  parameter int unsigned DATA_WIDTH     = ialu_pkg::DataWidthDef,
  parameter int unsigned ROOT_FRAC_BITS = ialu_pkg::RootFracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
  input  logic [2:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // int_result, root_q16
  output logic [1:0]  m_axis_tuser    // status
);
  import ialu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ialu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ialu_dp #(
    .DATA_WIDTH     (DATA_WIDTH),
    .ROOT_FRAC_BITS (ROOT_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (s_axis_tuser),
    .operand_a_i  (s_axis_tdata[31:0]),
    .operand_b_i  (s_axis_tdata[63:32]),
    .int_result_o (m_axis_tdata[31:0]),
    .root_q16_o   (m_axis_tdata[63:32]),
    .status_o     (m_axis_tuser)
  );

endmodule
